// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the serial display driver.
// Holds nothing but macro definitions; no other file dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SSDD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define SSDD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/ssdd_pkg.sv =====
// Shared types, constants and the segment lookup for the serial display driver.
// No dependencies; used by every module of the block.
package ssdd_pkg;

   localparam int DIGIT_COUNT_DEF = 4;
   localparam int INPUT_DIGITS    = 4;
   localparam int TICKS_W         = 10;
   localparam logic [TICKS_W-1:0] TICKS_RESET = 10'd10;

   // Frame and command bytes
   localparam logic [7:0] BYTE_DATA_CMD   = 8'h40;
   localparam logic [7:0] BYTE_ADDR_CMD   = 8'hC0;
   localparam logic [7:0] BYTE_DISP_ON    = 8'h88;
   localparam logic [7:0] BYTE_DISP_OFF   = 8'h80;
   localparam logic [7:0] BYTE_COLON_BIT  = 8'h80;
   localparam logic [7:0] BYTE_BLANK      = 8'h00;

   localparam int SEG_CODES = 17;
   localparam logic [7:0] SEG_TABLE [SEG_CODES] = '{
      8'h3F, 8'h30, 8'h5B, 8'h79, 8'h74, 8'h6D, 8'h6F, 8'h38, 8'h7F, 8'h7D,
      8'h7E, 8'h67, 8'h0F, 8'h73, 8'h4F, 8'h4E, 8'h5C
   };

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_DIGITS = 2'd1,
      CMD_BRIGHT = 2'd2,
      CMD_POWER  = 2'd3
   } cmd_type;

   // One classified beat handed from front to back
   typedef struct packed {
      cmd_type                           kind;
      logic [7:0]                        ctl_byte;
      logic [INPUT_DIGITS-1:0][7:0]      segs;
      logic                              dio_in;
   } entry_type;

   // One result beat
   typedef struct packed {
      logic clk_out;
      logic dio_out;
      logic dio_drive;
      logic busy_res;
      logic ack_missing;
      logic request_dropped;
   } rsp_type;

   // Segment code of a digit; codes past the table are blank
   function automatic logic [7:0] seg_of(input logic [4:0] code);
      logic [7:0] seg;
      seg = BYTE_BLANK;
      if (code < 5'(SEG_CODES)) begin
         seg = SEG_TABLE[code];
      end
      return seg;
   endfunction

endpackage

// ===== rtl/seven_segment_serial_display_driver_unit.sv =====
// Top level of the two-wire seven-segment display driver.
// Depends on ssdd_pkg, ssdd_front, ssdd_back and ssdd_queue.
//
// Usage:
//   Request channel (req_*): push a beat while req_full is low. cmd 0 is a
//   tick that advances the pin sequence; cmd 1..3 start a digit write, a
//   brightness frame or a power frame when the line is idle, otherwise the
//   request is dropped and flagged in its result.
//   Result channel (rsp_*): one result beat per request beat, in order, with
//   the clock and data line levels after that beat, the busy flag and the
//   acknowledge-missing and dropped flags. Pop while rsp_empty is low.
//   Config channel (csr_*): always ready; writes ticks_per_phase, and is to
//   be written only while no beats are outstanding.
// Timing:
//   A request beat is registered in the front queue, then stepped by the back
//   end into the result queue, where it can be popped; one beat per cycle
//   sustained while the result queue is not full, one sequencer step per beat.
//   Two-slot queues sit before and after the sequencer, so from empty the request
//   side takes four beats while rsp_pop is held low, then req_full rises.
// Reset: queues empty, lines idle high, ticks_per_phase back to 10.
module seven_segment_serial_display_driver_unit #(
   parameter int DIGIT_COUNT = ssdd_pkg::DIGIT_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_cmd,
   input  logic [4:0] req_digit_0,
   input  logic [4:0] req_digit_1,
   input  logic [4:0] req_digit_2,
   input  logic [4:0] req_digit_3,
   input  logic       req_colon,
   input  logic [2:0] req_level,
   input  logic       req_power_on,
   input  logic       req_dio_in,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_clk_out,
   output logic       rsp_dio_out,
   output logic       rsp_dio_drive,
   output logic       rsp_busy_res,
   output logic       rsp_ack_missing,
   output logic       rsp_request_dropped,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [ssdd_pkg::TICKS_W-1:0] csr_ticks_per_phase
);

   ssdd_pkg::entry_type ent;
   ssdd_pkg::rsp_type   res;
   ssdd_pkg::rsp_type   rsp_head;
   logic                ent_valid;
   logic                ent_pop;
   logic                res_push;
   logic                res_full;

   ssdd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_cmd      (req_cmd),
      .req_digit_0  (req_digit_0),
      .req_digit_1  (req_digit_1),
      .req_digit_2  (req_digit_2),
      .req_digit_3  (req_digit_3),
      .req_colon    (req_colon),
      .req_level    (req_level),
      .req_power_on (req_power_on),
      .req_dio_in   (req_dio_in),
      .ent_valid    (ent_valid),
      .ent          (ent),
      .ent_pop      (ent_pop)
   );

   ssdd_back #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .ent_valid           (ent_valid),
      .ent                 (ent),
      .ent_pop             (ent_pop),
      .res_full            (res_full),
      .res_push            (res_push),
      .res                 (res),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_ticks_per_phase (csr_ticks_per_phase)
   );

   ssdd_queue #(
      .WIDTH ($bits(ssdd_pkg::rsp_type))
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   // Unpack the head result beat
   assign rsp_clk_out         = rsp_head.clk_out;
   assign rsp_dio_out         = rsp_head.dio_out;
   assign rsp_dio_drive       = rsp_head.dio_drive;
   assign rsp_busy_res        = rsp_head.busy_res;
   assign rsp_ack_missing     = rsp_head.ack_missing;
   assign rsp_request_dropped = rsp_head.request_dropped;

endmodule

// ===== rtl/ssdd_queue.sv =====
// Two-slot queue used between the front and back and on the result side.
// Depends on ssdd_pkg for its default width only.
module ssdd_queue #(
   parameter int WIDTH = $bits(ssdd_pkg::rsp_type)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold payload; no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/ssdd_front.sv =====
// Front end: classifies request beats, encodes segment bytes, queues them.
// Depends on ssdd_pkg and ssdd_queue.
module ssdd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [1:0]          req_cmd,
   input  logic [4:0]          req_digit_0,
   input  logic [4:0]          req_digit_1,
   input  logic [4:0]          req_digit_2,
   input  logic [4:0]          req_digit_3,
   input  logic                req_colon,
   input  logic [2:0]          req_level,
   input  logic                req_power_on,
   input  logic                req_dio_in,
   output logic                ent_valid,
   output ssdd_pkg::entry_type ent,
   input  logic                ent_pop
);

   ssdd_pkg::entry_type enc;
   logic                ent_empty;

   // Classify and encode the incoming beat
   always_comb begin
      enc.kind   = ssdd_pkg::cmd_type'(req_cmd);
      enc.dio_in = req_dio_in;
      if (enc.kind == ssdd_pkg::CMD_BRIGHT) begin
         enc.ctl_byte = ssdd_pkg::BYTE_DISP_ON + {5'd0, req_level};
      end else begin
         enc.ctl_byte = req_power_on ? ssdd_pkg::BYTE_DISP_ON : ssdd_pkg::BYTE_DISP_OFF;
      end
      enc.segs[0] = ssdd_pkg::seg_of(req_digit_0);
      enc.segs[1] = ssdd_pkg::seg_of(req_digit_1);
      enc.segs[2] = ssdd_pkg::seg_of(req_digit_2) |
                    (req_colon ? ssdd_pkg::BYTE_COLON_BIT : ssdd_pkg::BYTE_BLANK);
      enc.segs[3] = ssdd_pkg::seg_of(req_digit_3);
   end

   ssdd_queue #(
      .WIDTH ($bits(ssdd_pkg::entry_type))
   ) u_ent_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (enc),
      .full      (req_full),
      .pop       (ent_pop),
      .pop_data  (ent),
      .empty     (ent_empty)
   );

   assign ent_valid = !ent_empty;

endmodule

// ===== rtl/ssdd_back.sv =====
// Back end: pin sequencer that runs start, bytes, acknowledge and stop phases.
// Depends on ssdd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ssdd_back #(
   parameter int DIGIT_COUNT = ssdd_pkg::DIGIT_COUNT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        ent_valid,
   input  ssdd_pkg::entry_type         ent,
   output logic                        ent_pop,
   input  logic                        res_full,
   output logic                        res_push,
   output ssdd_pkg::rsp_type           res,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ssdd_pkg::TICKS_W-1:0] csr_ticks_per_phase
);

   localparam int STORE_DEPTH = DIGIT_COUNT + 2;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int TW          = ssdd_pkg::TICKS_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START_HIGH,
      ST_START_HOLD,
      ST_BIT_LOW,
      ST_BIT_HIGH,
      ST_ACK_LOW,
      ST_ACK_HIGH,
      ST_ACK_END,
      ST_STOP_LOW,
      ST_STOP_DLOW,
      ST_STOP_CHIGH
   } step_type;

   step_type         step_ff, step_in, enter_step;
   logic             enter_en;
   logic [CNT_W-1:0] byte_index_ff, byte_index_in;
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [CNT_W-1:0] frame_end;
   logic [2:0]       bit_index_ff, bit_index_in;
   logic [TW-1:0]    timer_ff, timer_in;
   logic [TW-1:0]    ticks_ff;
   logic [TW-1:0]    limit;
   logic [TW:0]      timer_sum;
   logic             clk_ff, clk_in;
   logic             dio_ff, dio_in;
   logic             drive_ff, drive_in;
   logic             take;
   logic             miss;
   logic             dropped;
   logic             store_we;
   logic [7:0]       store_ff [STORE_DEPTH];
   logic [7:0]       load_byte [STORE_DEPTH];
   logic [7:0]       cur_byte;

   assign take      = ent_valid && !res_full;
   assign ent_pop   = take;
   assign res_push  = take;
   assign csr_ready = 1'b1;
   assign limit     = (ticks_ff == '0) ? TW'(1) : ticks_ff;
   assign timer_sum = {1'b0, timer_ff} + (TW+1)'(1);
   assign frame_end = (byte_count_ff > CNT_W'(1)) ? byte_count_ff - CNT_W'(1) : CNT_W'(1);

   // Bytes to load on a request: frame, digits left to right, frame
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         load_byte[i] = ssdd_pkg::BYTE_BLANK;
      end
      if (ent.kind == ssdd_pkg::CMD_DIGITS) begin
         load_byte[0] = ssdd_pkg::BYTE_DATA_CMD;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (DIGIT_COUNT - 1 - i < ssdd_pkg::INPUT_DIGITS) begin
               load_byte[1 + i] = ent.segs[DIGIT_COUNT - 1 - i];
            end
         end
         load_byte[STORE_DEPTH - 1] = ssdd_pkg::BYTE_ADDR_CMD;
      end else begin
         load_byte[0] = ent.ctl_byte;
      end
   end

   // Sequencer step for one beat
   always_comb begin
      byte_index_in = byte_index_ff;
      byte_count_in = byte_count_ff;
      bit_index_in  = bit_index_ff;
      timer_in      = timer_ff;
      enter_en      = 1'b0;
      enter_step    = ST_IDLE;
      miss          = 1'b0;
      dropped       = 1'b0;
      store_we      = 1'b0;
      if (take) begin
         if (ent.kind != ssdd_pkg::CMD_TICK) begin
            if (step_ff != ST_IDLE) begin
               dropped = 1'b1;
            end else begin
               store_we      = 1'b1;
               byte_count_in = (ent.kind == ssdd_pkg::CMD_DIGITS) ?
                               CNT_W'(STORE_DEPTH) : CNT_W'(1);
               byte_index_in = '0;
               bit_index_in  = '0;
               timer_in      = '0;
               enter_en      = 1'b1;
               enter_step    = ST_START_HIGH;
            end
         end else if (step_ff != ST_IDLE) begin
            if (timer_sum >= {1'b0, limit}) begin
               timer_in = '0;
               enter_en = 1'b1;
               case (step_ff)
                  ST_START_HIGH: enter_step = ST_START_HOLD;
                  ST_START_HOLD: begin
                     bit_index_in = '0;
                     enter_step   = ST_BIT_LOW;
                  end
                  ST_BIT_LOW: enter_step = ST_BIT_HIGH;
                  ST_BIT_HIGH: begin
                     if (bit_index_ff == 3'd7) begin
                        enter_step = ST_ACK_LOW;
                     end else begin
                        bit_index_in = bit_index_ff + 3'd1;
                        enter_step   = ST_BIT_LOW;
                     end
                  end
                  ST_ACK_LOW: enter_step = ST_ACK_HIGH;
                  ST_ACK_HIGH: begin
                     miss       = ent.dio_in;
                     enter_step = ST_ACK_END;
                  end
                  ST_ACK_END: begin
                     byte_index_in = byte_index_ff + CNT_W'(1);
                     if (byte_index_in == frame_end || byte_index_in >= byte_count_ff) begin
                        enter_step = ST_STOP_LOW;
                     end else begin
                        bit_index_in = '0;
                        enter_step   = ST_BIT_LOW;
                     end
                  end
                  ST_STOP_LOW:  enter_step = ST_STOP_DLOW;
                  ST_STOP_DLOW: enter_step = ST_STOP_CHIGH;
                  ST_STOP_CHIGH: begin
                     enter_step = (byte_index_ff < byte_count_ff) ? ST_START_HIGH : ST_IDLE;
                  end
                  default: enter_step = ST_IDLE;
               endcase
            end else begin
               timer_in = timer_sum[TW-1:0];
            end
         end
      end
   end

   // Pick the byte that the next bit comes from
   always_comb begin
      cur_byte = ssdd_pkg::BYTE_BLANK;
      if (byte_index_in < CNT_W'(STORE_DEPTH)) begin
         cur_byte = store_ff[byte_index_in[IDX_W-1:0]];
      end
   end

   // Drive pin levels on entry to a phase
   always_comb begin
      step_in  = step_ff;
      clk_in   = clk_ff;
      dio_in   = dio_ff;
      drive_in = drive_ff;
      if (enter_en) begin
         step_in = enter_step;
         case (enter_step)
            ST_START_HIGH: begin
               clk_in = 1'b1; dio_in = 1'b1; drive_in = 1'b1;
            end
            ST_START_HOLD: begin
               clk_in = 1'b1; dio_in = 1'b0; drive_in = 1'b1;
            end
            ST_BIT_LOW: begin
               clk_in = 1'b0; dio_in = cur_byte[bit_index_in]; drive_in = 1'b1;
            end
            ST_BIT_HIGH:  clk_in = 1'b1;
            ST_ACK_LOW: begin
               clk_in = 1'b0; drive_in = 1'b0;
            end
            ST_ACK_HIGH:  clk_in = 1'b1;
            ST_ACK_END:   clk_in = 1'b0;
            ST_STOP_LOW: begin
               clk_in = 1'b0; drive_in = 1'b1;
            end
            ST_STOP_DLOW:  dio_in = 1'b0;
            ST_STOP_CHIGH: clk_in = 1'b1;
            default: begin
               clk_in = 1'b1; dio_in = 1'b1; drive_in = 1'b1;
            end
         endcase
      end
   end

   // Result beat reflects the state after this step
   always_comb begin
      res.clk_out         = clk_in;
      res.dio_out         = dio_in;
      res.dio_drive       = drive_in;
      res.busy_res        = (step_in != ST_IDLE);
      res.ack_missing     = miss;
      res.request_dropped = dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= ST_IDLE;
         byte_index_ff <= '0;
         byte_count_ff <= '0;
         bit_index_ff  <= '0;
         timer_ff      <= '0;
         clk_ff        <= 1'b1;
         dio_ff        <= 1'b1;
         drive_ff      <= 1'b1;
         ticks_ff      <= ssdd_pkg::TICKS_RESET;
      end else begin
         step_ff       <= step_in;
         byte_index_ff <= byte_index_in;
         byte_count_ff <= byte_count_in;
         bit_index_ff  <= bit_index_in;
         timer_ff      <= timer_in;
         clk_ff        <= clk_in;
         dio_ff        <= dio_in;
         drive_ff      <= drive_in;
         if (csr_valid) begin
            ticks_ff <= csr_ticks_per_phase;
         end
      end
   end

   // Load the byte store on an accepted request; undefined until then
   always_ff @(posedge clock) begin
      if (store_we) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= load_byte[i];
         end
      end
   end

   `SSDD_ASSERT_IMPLY(a_drop_when_busy, clock, reset, take && dropped, step_ff != ST_IDLE)
   `SSDD_ASSERT_IMPLY(a_idle_lines_high, clock, reset, step_ff == ST_IDLE, clk_ff && dio_ff && drive_ff)
   `SSDD_ASSERT_IMPLY(a_miss_in_ack, clock, reset, miss, step_ff == ST_ACK_HIGH)
   `SSDD_ASSERT_NEXT(a_request_starts, clock, reset, store_we, step_ff == ST_START_HIGH && byte_index_ff == '0)

endmodule
